@@ rtl/cbct_pkg.sv @@
// Shared widths and the hand-over record for the circle and box overlap test.
`default_nettype none

package cbct_pkg;

  // Coordinates are signed fixed point with eight fraction bits; sizes use the same scale.
  localparam int COORD_BITS = 24;
  localparam int SIZE_BITS  = COORD_BITS - 2;
  // A sum of two sizes, and so any radius that is tested.
  localparam int RAD_BITS   = SIZE_BITS + 1;
  localparam int SQ_BITS    = 2 * RAD_BITS;
  localparam int SUM_BITS   = SQ_BITS + 1;

  localparam int IN_FIELD_BITS = 4 * COORD_BITS + 4 * SIZE_BITS;
  localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int IN_USER_BITS  = 3;
  localparam int OUT_DATA_BITS = 8;

  // Per-axis distances, radius for the squared test, and the enable and box-pair flags.
  typedef struct packed {
    logic                  en;
    logic                  is_bb;
    logic                  bb_hit;
    logic [COORD_BITS-1:0] ex;
    logic [COORD_BITS-1:0] ey;
    logic [RAD_BITS-1:0]   r;
  } cbct_axes_t;

endpackage

`default_nettype wire

@@ rtl/cbct_radius_test.sv @@
// Back half of the pipeline: range reject, squaring and the final strict compare.
`default_nettype none

module cbct_radius_test
  import cbct_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire cbct_axes_t in_axes_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            out_hit_o
);

  logic                v3_q, v4_q;
  logic                rdy3, rdy4;
  logic                en3_q, bb3_q, bbhit3_q, rej3_q;
  logic [SQ_BITS-1:0]  ex2_q, ey2_q, r22_q;
  logic                rej3_d;
  logic [SQ_BITS-1:0]  ex2_d, ey2_d, r22_d;
  logic [RAD_BITS-1:0] ex_lo, ey_lo;
  logic [SUM_BITS-1:0] dist2;
  logic                hit4_d, hit4_q;

  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign in_ready_o = rdy3;

  // Any axis at or past the radius misses, which also bounds both squares.
  assign rej3_d = (in_axes_i.ex >= COORD_BITS'(in_axes_i.r)) ||
                  (in_axes_i.ey >= COORD_BITS'(in_axes_i.r));
  assign ex_lo  = in_axes_i.ex[RAD_BITS-1:0];
  assign ey_lo  = in_axes_i.ey[RAD_BITS-1:0];
  assign ex2_d  = SQ_BITS'(ex_lo) * SQ_BITS'(ex_lo);
  assign ey2_d  = SQ_BITS'(ey_lo) * SQ_BITS'(ey_lo);
  assign r22_d  = SQ_BITS'(in_axes_i.r) * SQ_BITS'(in_axes_i.r);

  assign dist2  = SUM_BITS'(ex2_q) + SUM_BITS'(ey2_q);
  assign hit4_d = en3_q && (bb3_q ? bbhit3_q : (!rej3_q && (dist2 < SUM_BITS'(r22_q))));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy3) begin
        v3_q <= in_valid_i;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && in_valid_i) begin
      en3_q    <= in_axes_i.en;
      bb3_q    <= in_axes_i.is_bb;
      bbhit3_q <= in_axes_i.bb_hit;
      rej3_q   <= rej3_d;
      ex2_q    <= ex2_d;
      ey2_q    <= ey2_d;
      r22_q    <= r22_d;
    end
    if (rdy4 && v3_q) begin
      hit4_q <= hit4_d;
    end
  end

  assign out_valid_o = v4_q;
  assign out_hit_o   = hit4_q;

  a_disabled_misses : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && rdy4 && !en3_q) |=> !hit4_q)
    else $error("disabled item reported a hit");

  a_reject_misses : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && rdy4 && !bb3_q && rej3_q) |=> !hit4_q)
    else $error("axis beyond radius reported a hit");

  a_box_pair_passes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && rdy4 && bb3_q) |=> (hit4_q == $past(bbhit3_q && en3_q)))
    else $error("box pair result differs from the per-axis test");

endmodule

`default_nettype wire

@@ rtl/circle_box_collision_test.sv @@
// Top level of the circle and axis-aligned box overlap test.
//
// The block takes one request per cycle on the slave stream unless stalled: two
// shapes, each a circle or an axis-aligned box, with centres already including
// their hitbox offsets. It returns one result per request on the master stream,
// bit 0 of m_axis_tdata being 1 when the shapes overlap strictly (touching is a
// miss). A request whose collision flag is clear always returns a miss.
//
// The work runs through four register stages: absolute centre differences and
// size sums; selection of the per-axis excess and radius for the pair's kind;
// the range reject and three parallel squarings; and the final strict compare
// of the squared distance with the squared radius. One request is taken in
// every cycle while the receiver keeps up, so the throughput is one per cycle.
//
// Each stage carries a valid bit and moves whenever the stage after it is
// empty or moving, so a stalled receiver backs up the pipeline one stage at a
// time and no request is lost or repeated. Reset clears the valid bits only;
// the block is ready for a request as soon as reset is released.
`default_nettype none

module circle_box_collision_test
  import cbct_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // a_x, a_y, a_size_x, a_size_y, b_x, b_y, b_size_x, b_size_y
  input  wire logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  // collision_enabled, a_is_box, b_is_box
  input  wire logic [IN_USER_BITS-1:0]  s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // hit, then zero padding
  output logic [OUT_DATA_BITS-1:0]      m_axis_tdata
);

  localparam int AX_LO  = 0;
  localparam int AY_LO  = AX_LO + COORD_BITS;
  localparam int ASX_LO = AY_LO + COORD_BITS;
  localparam int ASY_LO = ASX_LO + SIZE_BITS;
  localparam int BX_LO  = ASY_LO + SIZE_BITS;
  localparam int BY_LO  = BX_LO + COORD_BITS;
  localparam int BSX_LO = BY_LO + COORD_BITS;
  localparam int BSY_LO = BSX_LO + SIZE_BITS;

  localparam int USER_EN    = 0;
  localparam int USER_A_BOX = 1;
  localparam int USER_B_BOX = 2;

  // Pair kind, shape A in the upper bit.
  typedef enum logic [1:0] {
    PAIR_CC = 2'b00,
    PAIR_CB = 2'b01,
    PAIR_BC = 2'b10,
    PAIR_BB = 2'b11
  } pair_e;

  // Distance left over outside a half extent, zero when inside.
  function automatic logic [COORD_BITS-1:0] excess(input logic [COORD_BITS-1:0] d,
                                                   input logic [SIZE_BITS-1:0]  h);
    logic [COORD_BITS-1:0] hw;
    hw = COORD_BITS'(h);
    return (d > hw) ? (d - hw) : '0;
  endfunction

  // Field views of the incoming request.
  logic signed [COORD_BITS-1:0] in_ax, in_ay, in_bx, in_by;
  logic signed [COORD_BITS:0]   diff_x, diff_y;
  logic [COORD_BITS-1:0]        dx_d, dy_d;

  assign in_ax  = s_axis_tdata[AX_LO +: COORD_BITS];
  assign in_ay  = s_axis_tdata[AY_LO +: COORD_BITS];
  assign in_bx  = s_axis_tdata[BX_LO +: COORD_BITS];
  assign in_by  = s_axis_tdata[BY_LO +: COORD_BITS];
  assign diff_x = (COORD_BITS+1)'(in_ax) - (COORD_BITS+1)'(in_bx);
  assign diff_y = (COORD_BITS+1)'(in_ay) - (COORD_BITS+1)'(in_by);
  // The magnitude of a difference always fits back into the coordinate width.
  assign dx_d   = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
  assign dy_d   = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];

  // Stage one: differences and size sums.
  logic                  v1_q, v2_q;
  logic                  rdy1, rdy2, sub_ready;
  logic                  en1_q;
  pair_e                 pair1_q;
  logic [COORD_BITS-1:0] dx1_q, dy1_q;
  logic [RAD_BITS-1:0]   rsum1_q, hsum1_q;
  logic [SIZE_BITS-1:0]  asx1_q, asy1_q, bsx1_q, bsy1_q;

  // Stage two: per-axis excess and radius for the pair's kind.
  cbct_axes_t axes_d, axes2_q;

  assign rdy2          = !v2_q || sub_ready;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  always_comb begin
    axes_d        = '0;
    axes_d.en     = en1_q;
    axes_d.is_bb  = (pair1_q == PAIR_BB);
    axes_d.bb_hit = (dx1_q < COORD_BITS'(rsum1_q)) && (dy1_q < COORD_BITS'(hsum1_q));
    unique case (pair1_q)
      PAIR_CC: begin
        axes_d.ex = dx1_q;
        axes_d.ey = dy1_q;
        axes_d.r  = rsum1_q;
      end
      PAIR_CB: begin
        axes_d.ex = excess(dx1_q, bsx1_q);
        axes_d.ey = excess(dy1_q, bsy1_q);
        axes_d.r  = RAD_BITS'(asx1_q);
      end
      PAIR_BC: begin
        axes_d.ex = excess(dx1_q, asx1_q);
        axes_d.ey = excess(dy1_q, asy1_q);
        axes_d.r  = RAD_BITS'(bsx1_q);
      end
      PAIR_BB: begin
        // Only the per-axis test counts for two boxes.
        axes_d.ex = '0;
        axes_d.ey = '0;
        axes_d.r  = '0;
      end
      default: begin
        axes_d.ex = '0;
        axes_d.ey = '0;
        axes_d.r  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= s_axis_tvalid;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid) begin
      en1_q   <= s_axis_tuser[USER_EN];
      pair1_q <= pair_e'({s_axis_tuser[USER_A_BOX], s_axis_tuser[USER_B_BOX]});
      dx1_q   <= dx_d;
      dy1_q   <= dy_d;
      asx1_q  <= s_axis_tdata[ASX_LO +: SIZE_BITS];
      asy1_q  <= s_axis_tdata[ASY_LO +: SIZE_BITS];
      bsx1_q  <= s_axis_tdata[BSX_LO +: SIZE_BITS];
      bsy1_q  <= s_axis_tdata[BSY_LO +: SIZE_BITS];
      rsum1_q <= RAD_BITS'(s_axis_tdata[ASX_LO +: SIZE_BITS]) +
                 RAD_BITS'(s_axis_tdata[BSX_LO +: SIZE_BITS]);
      hsum1_q <= RAD_BITS'(s_axis_tdata[ASY_LO +: SIZE_BITS]) +
                 RAD_BITS'(s_axis_tdata[BSY_LO +: SIZE_BITS]);
    end
    if (rdy2 && v1_q) begin
      axes2_q <= axes_d;
    end
  end

  // Stages three and four; stage four is the output register.
  logic hit_o;

  cbct_radius_test u_radius (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v2_q),
    .in_ready_o  (sub_ready),
    .in_axes_i   (axes2_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_hit_o   (hit_o)
  );

  assign m_axis_tdata = {(OUT_DATA_BITS-1)'(0), hit_o};

endmodule

`default_nettype wire

@@ tb/sv/circle_box_collision_test_tb.sv @@
// Self-checking testbench for the circle and axis-aligned box overlap test.
`timescale 1ns / 100ps

module circle_box_collision_test_tb;
  import cbct_pkg::*;

  // Shape kinds as they travel in the request flags.
  typedef enum bit {
    SHAPE_CIRCLE = 1'b0,
    SHAPE_BOX    = 1'b1
  } shape_kind_e;

  // One request: two shapes whose centres already include their hitbox offsets.
  typedef struct {
    bit                           enabled;
    shape_kind_e                  a_kind;
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic [SIZE_BITS-1:0]         a_sx;
    logic [SIZE_BITS-1:0]         a_sy;
    shape_kind_e                  b_kind;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic [SIZE_BITS-1:0]         b_sx;
    logic [SIZE_BITS-1:0]         b_sy;
  } shape_pair_t;

  localparam int COORD_MAX  = 8388607;
  localparam int COORD_MIN  = -8388608;
  localparam int SIZE_MAX   = 4194303;
  // One unit in fixed point with eight fraction bits.
  localparam int UNIT       = 256;
  // Cycles without any request or result moving before the run is abandoned.
  localparam int IDLE_LIMIT = 5000;
  // Length of the deliberate receiver hold-off.
  localparam int LONG_HOLD  = 200;
  // Cycles to let pass once nothing is expected any more.
  localparam int DRAIN_CYCLES = 12;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [IN_DATA_BITS-1:0] s_axis_tdata;
  logic [IN_USER_BITS-1:0] s_axis_tuser;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;

  // Hit flags predicted for accepted requests, oldest first.
  bit pending_hits[$];
  int error_count;
  int idle_cycles;
  // Idling switches for either side, and the request for one long hold-off.
  bit send_gaps_on;
  bit recv_stalls_on;
  bit long_hold_req;

  circle_box_collision_test u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction. Centres are moved into offset-binary form so that plain
  // unsigned subtraction gives the exact distance along each axis; every
  // square then fits comfortably in 64 bits.
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] centre_gap(logic [COORD_BITS-1:0] p,
                                             logic [COORD_BITS-1:0] q);
    logic [63:0] po;
    logic [63:0] qo;
    po = 64'({~p[COORD_BITS-1], p[COORD_BITS-2:0]});
    qo = 64'({~q[COORD_BITS-1], q[COORD_BITS-2:0]});
    return (po > qo) ? po - qo : qo - po;
  endfunction

  // How far a distance reaches beyond a half extent, or zero when inside it.
  function automatic logic [63:0] beyond_extent(logic [63:0] d, logic [63:0] h);
    return (d > h) ? d - h : 64'd0;
  endfunction

  // Strict disc test. A distance that already reaches the radius on one axis
  // is a miss without squaring, which also makes a zero radius always miss.
  function automatic bit within_disc(logic [63:0] ex, logic [63:0] ey, logic [63:0] r);
    if (ex >= r || ey >= r) begin
      return 1'b0;
    end
    return (ex * ex + ey * ey) < (r * r);
  endfunction

  function automatic bit predict_overlap(shape_pair_t p);
    logic [63:0] dx;
    logic [63:0] dy;
    logic [63:0] asx;
    logic [63:0] asy;
    logic [63:0] bsx;
    logic [63:0] bsy;
    dx  = centre_gap(p.a_x, p.b_x);
    dy  = centre_gap(p.a_y, p.b_y);
    asx = 64'(p.a_sx);
    asy = 64'(p.a_sy);
    bsx = 64'(p.b_sx);
    bsy = 64'(p.b_sy);
    if (!p.enabled) begin
      return 1'b0;
    end
    if (p.a_kind == SHAPE_CIRCLE && p.b_kind == SHAPE_CIRCLE) begin
      return within_disc(dx, dy, asx + bsx);
    end else if (p.a_kind == SHAPE_CIRCLE) begin
      return within_disc(beyond_extent(dx, bsx), beyond_extent(dy, bsy), asx);
    end else if (p.b_kind == SHAPE_CIRCLE) begin
      return within_disc(beyond_extent(dx, asx), beyond_extent(dy, asy), bsx);
    end
    return (dx < asx + bsx) && (dy < asy + bsy);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic shape_pair_t make_pair(bit en, shape_kind_e ak, int ax, int ay,
                                            int asx, int asy, shape_kind_e bk,
                                            int bx, int by, int bsx, int bsy);
    shape_pair_t p;
    p.enabled = en;
    p.a_kind  = ak;
    p.a_x     = COORD_BITS'(ax);
    p.a_y     = COORD_BITS'(ay);
    p.a_sx    = SIZE_BITS'(asx);
    p.a_sy    = SIZE_BITS'(asy);
    p.b_kind  = bk;
    p.b_x     = COORD_BITS'(bx);
    p.b_y     = COORD_BITS'(by);
    p.b_sx    = SIZE_BITS'(bsx);
    p.b_sy    = SIZE_BITS'(bsy);
    return p;
  endfunction

  // Most pairs are placed close together with sizes of one random scale, so
  // that hits, near misses and exact contact all turn up; the rest are noise.
  function automatic shape_pair_t random_pair();
    shape_pair_t p;
    int unsigned style;
    int unsigned scale;
    int unsigned size_mask;
    int          span_x;
    int          span_y;
    int          off_x;
    int          off_y;
    style     = $urandom_range(0, 9);
    p.enabled = ($urandom_range(0, 9) != 0);
    p.a_kind  = shape_kind_e'($urandom_range(0, 1));
    p.b_kind  = shape_kind_e'($urandom_range(0, 1));
    p.a_x     = COORD_BITS'($urandom);
    p.a_y     = COORD_BITS'($urandom);
    if (style < 2) begin
      p.a_sx = SIZE_BITS'($urandom);
      p.a_sy = SIZE_BITS'($urandom);
      p.b_x  = COORD_BITS'($urandom);
      p.b_y  = COORD_BITS'($urandom);
      p.b_sx = SIZE_BITS'($urandom);
      p.b_sy = SIZE_BITS'($urandom);
      return p;
    end
    scale     = $urandom_range(0, SIZE_BITS);
    size_mask = (32'd1 << scale) - 32'd1;
    p.a_sx    = SIZE_BITS'($urandom & size_mask);
    p.a_sy    = SIZE_BITS'($urandom & size_mask);
    p.b_sx    = SIZE_BITS'($urandom & size_mask);
    p.b_sy    = SIZE_BITS'($urandom & size_mask);
    span_x    = int'(p.a_sx) + int'(p.b_sx);
    span_y    = int'(p.a_sy) + int'(p.b_sy);
    if (style == 2) begin
      // Exact contact along one axis, centred on the other.
      off_x = 0;
      off_y = 0;
      if ($urandom_range(0, 1) == 0) begin
        off_x = ($urandom_range(0, 1) == 0) ? span_x : -span_x;
      end else begin
        off_y = ($urandom_range(0, 1) == 0) ? span_y : -span_y;
      end
    end else begin
      off_x = int'($urandom_range(0, 2 * span_x + 2)) - span_x - 1;
      off_y = int'($urandom_range(0, 2 * span_y + 2)) - span_y - 1;
    end
    p.b_x = COORD_BITS'(int'(p.a_x) + off_x);
    p.b_y = COORD_BITS'(int'(p.a_y) + off_y);
    return p;
  endfunction

  // Gaps and stalls are drawn afresh for every request and result.
  function automatic int unsigned idle_draw(bit enabled);
    return enabled ? $urandom_range(0, 15) : 0;
  endfunction

  // Offers one request, starting and ending at a falling edge. The predicted
  // hit is queued at the rising edge at which the request is accepted. When
  // no gap is drawn, tvalid simply stays high from the previous request.
  task automatic send_request(shape_pair_t p);
    int unsigned gap;
    gap = idle_draw(send_gaps_on);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {p.b_sy, p.b_sx, p.b_y, p.b_x, p.a_sy, p.a_sx, p.a_y, p.a_x};
    s_axis_tuser  <= {p.b_kind, p.a_kind, p.enabled};
    s_axis_tvalid <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    pending_hits.push_back(predict_overlap(p));
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: the receiver stalls at random before each result, and once,
  // on request, holds off for a long stretch so that the pipeline fills up
  // and the block has to refuse requests.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = idle_draw(recv_stalls_on);
      if (long_hold_req) begin
        stall = stall + LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do begin
        @(posedge clk_i);
      end while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  // Every accepted result is compared with the oldest prediction.
  always @(posedge clk_i) begin
    bit want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: result with no request outstanding, expected none, actual hit %0b",
                 $time, m_axis_tdata[0]);
        error_count++;
      end else begin
        want = pending_hits.pop_front();
        if (m_axis_tdata[0] !== want) begin
          $display("%0t: hit mismatch, expected %0b, actual %0b",
                   $time, want, m_axis_tdata[0]);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a stretch in which neither a request nor a result moves.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Hand-picked requests: each pairing of kinds just overlapping and just
  // touching, zero sizes, the disabled flag, and extreme coordinates and sizes.
  task automatic test_corner_cases();
    // Circles overlapping by one LSB, then touching exactly.
    send_request(make_pair(1, SHAPE_CIRCLE, 0, 0, UNIT, 0, SHAPE_CIRCLE, UNIT, 0, 1, 0));
    send_request(make_pair(1, SHAPE_CIRCLE, 0, 0, 200, 0, SHAPE_CIRCLE, 300, 0, 100, 0));
    // A 3-4-5 triangle: radius sum 5 touches, 6 overlaps.
    send_request(make_pair(1, SHAPE_CIRCLE, 0, 0, 2, 7, SHAPE_CIRCLE, 3, 4, 3, 9));
    send_request(make_pair(1, SHAPE_CIRCLE, 0, 0, 3, 7, SHAPE_CIRCLE, -3, -4, 3, 9));
    // Zero radii on the same centre never hit.
    send_request(make_pair(1, SHAPE_CIRCLE, 5, 5, 0, 0, SHAPE_CIRCLE, 5, 5, 0, 0));
    // Largest radii: opposite corners of the range miss, shared centre hits.
    send_request(make_pair(1, SHAPE_CIRCLE, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX,
                           SHAPE_CIRCLE, COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX));
    send_request(make_pair(1, SHAPE_CIRCLE, COORD_MAX, COORD_MIN, SIZE_MAX, 0,
                           SHAPE_CIRCLE, COORD_MAX, COORD_MIN, SIZE_MAX, 0));
    // Circle against a box side: touching, then overlapping.
    send_request(make_pair(1, SHAPE_CIRCLE, 0, 0, 10, 0, SHAPE_BOX, 15, 0, 5, 5));
    send_request(make_pair(1, SHAPE_CIRCLE, 0, 0, 10, 0, SHAPE_BOX, 15, 0, 6, 5));
    // Circle against a box corner at distance 5.
    send_request(make_pair(1, SHAPE_CIRCLE, 0, 0, 5, 0, SHAPE_BOX, 7, 8, 4, 4));
    send_request(make_pair(1, SHAPE_CIRCLE, 0, 0, 6, 0, SHAPE_BOX, -7, -8, 4, 4));
    // The same with the box first.
    send_request(make_pair(1, SHAPE_BOX, 7, 8, 4, 4, SHAPE_CIRCLE, 0, 0, 5, 3));
    send_request(make_pair(1, SHAPE_BOX, -7, 8, 4, 4, SHAPE_CIRCLE, 0, 0, 6, 3));
    // A zero-radius circle at the centre of a box still misses.
    send_request(make_pair(1, SHAPE_BOX, 0, 0, 50, 50, SHAPE_CIRCLE, 0, 0, 0, 0));
    // Boxes: overlap, touching in x, touching in y, zero extents.
    send_request(make_pair(1, SHAPE_BOX, 0, 0, 10, 10, SHAPE_BOX, 19, -19, 10, 10));
    send_request(make_pair(1, SHAPE_BOX, 0, 0, 10, 10, SHAPE_BOX, 20, 0, 10, 10));
    send_request(make_pair(1, SHAPE_BOX, 0, 0, 10, 10, SHAPE_BOX, 0, -20, 10, 10));
    send_request(make_pair(1, SHAPE_BOX, 3, 3, 0, 0, SHAPE_BOX, 3, 3, 0, 0));
    // Largest boxes at opposite extremes, and all-ones fields.
    send_request(make_pair(1, SHAPE_BOX, COORD_MIN, COORD_MAX, SIZE_MAX, SIZE_MAX,
                           SHAPE_BOX, COORD_MAX, COORD_MIN, SIZE_MAX, SIZE_MAX));
    send_request(make_pair(1, SHAPE_BOX, -1, -1, SIZE_MAX, SIZE_MAX,
                           SHAPE_BOX, -1, -1, SIZE_MAX, SIZE_MAX));
    // Collision disabled: every pairing overlaps heavily yet must miss.
    send_request(make_pair(0, SHAPE_CIRCLE, 0, 0, 100, 0, SHAPE_CIRCLE, 0, 0, 100, 0));
    send_request(make_pair(0, SHAPE_CIRCLE, 0, 0, 100, 0, SHAPE_BOX, 0, 0, 100, 100));
    send_request(make_pair(0, SHAPE_BOX, 0, 0, 100, 100, SHAPE_CIRCLE, 0, 0, 100, 0));
    send_request(make_pair(0, SHAPE_BOX, -1, -1, SIZE_MAX, SIZE_MAX,
                           SHAPE_BOX, -1, -1, SIZE_MAX, SIZE_MAX));
  endtask

  // Random pairs in blocks, each block with its own mix of gaps and stalls,
  // so that some blocks run with no idling on one or both sides.
  task automatic test_random_traffic(int blocks, int per_block);
    for (int b = 0; b < blocks; b++) begin
      send_gaps_on   = ($urandom_range(0, 3) != 0);
      recv_stalls_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < per_block; i++) begin
        send_request(random_pair());
      end
    end
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
  endtask

  // Back-to-back requests and results at the full rate of one per cycle.
  task automatic test_full_rate(int count);
    send_gaps_on   = 1'b0;
    recv_stalls_on = 1'b0;
    for (int i = 0; i < count; i++) begin
      send_request(random_pair());
    end
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
  endtask

  // The receiver holds off for a long stretch while requests keep coming
  // without gaps; the block must fill up, refuse requests, and lose nothing.
  task automatic test_receiver_hold(int count);
    send_gaps_on  = 1'b0;
    long_hold_req = 1'b1;
    for (int i = 0; i < count; i++) begin
      send_request(random_pair());
    end
    send_gaps_on = 1'b1;
  endtask

  initial begin
    error_count    = 0;
    idle_cycles    = 0;
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
    long_hold_req  = 1'b0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_corner_cases();
    test_random_traffic(14, 100);
    test_full_rate(200);
    test_receiver_hold(100);
    s_axis_tvalid <= 1'b0;

    // Wait for every outstanding result, then for the drain period so that a
    // stray extra result would still be seen.
    while (pending_hits.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/cbct_pkg.sv
rtl/cbct_radius_test.sv
rtl/circle_box_collision_test.sv
tb/sv/circle_box_collision_test_tb.sv
